>>> hdl/ukct_pkg.sv
// Shared types, codes and microprogram for the unique-key compacting table.
`default_nettype none
package ukct_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int COUNT_W = 7;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        key;
		logic signed [31:0] price;
	} cmd_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] found_price;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0]        key;
		logic signed [31:0] price;
	} entry_t;

	// Step addresses of the microprogram.
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] STEP_IDLE    = 4'd0;
	localparam logic [PC_W-1:0] STEP_SCAN    = 4'd1;
	localparam logic [PC_W-1:0] STEP_CMP     = 4'd2;
	localparam logic [PC_W-1:0] STEP_HIT     = 4'd3;
	localparam logic [PC_W-1:0] STEP_SH_RD   = 4'd4;
	localparam logic [PC_W-1:0] STEP_SH_WR   = 4'd5;
	localparam logic [PC_W-1:0] STEP_RM_DONE = 4'd6;
	localparam logic [PC_W-1:0] STEP_MISS    = 4'd7;
	localparam logic [PC_W-1:0] STEP_RESP    = 4'd8;

	// Jump conditions.
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] COND_NONE      = 3'd0;
	localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd1;
	localparam logic [COND_W-1:0] COND_END       = 3'd2;
	localparam logic [COND_W-1:0] COND_NOMATCH   = 3'd3;
	localparam logic [COND_W-1:0] COND_NOTREMOVE = 3'd4;
	localparam logic [COND_W-1:0] COND_SHEND     = 3'd5;

	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
		logic              rd_en;
		logic              rd_next;
		logic              idx_inc_taken;
		logic              hit;
		logic              shift_wr;
		logic              rm_done;
		logic              append;
		logic              respond;
	} ctl_t;

	typedef struct packed {
		logic at_end;
		logic match;
		logic is_remove;
		logic shift_end;
	} stat_t;

	// Control store: one control word per step.
	function automatic ctl_t ucode(logic [PC_W-1:0] pc);
		ctl_t w;
		begin
			w = '0;
			unique case (pc)
				STEP_SCAN: begin
					w.cond = COND_END;
					w.target = STEP_MISS;
					w.rd_en = 1'b1;
				end
				STEP_CMP: begin
					w.cond = COND_NOMATCH;
					w.target = STEP_SCAN;
					w.idx_inc_taken = 1'b1;
				end
				STEP_HIT: begin
					w.cond = COND_NOTREMOVE;
					w.target = STEP_RESP;
					w.hit = 1'b1;
				end
				STEP_SH_RD: begin
					w.cond = COND_SHEND;
					w.target = STEP_RM_DONE;
					w.rd_en = 1'b1;
					w.rd_next = 1'b1;
				end
				STEP_SH_WR: begin
					w.cond = COND_ALWAYS;
					w.target = STEP_SH_RD;
					w.shift_wr = 1'b1;
				end
				STEP_RM_DONE: begin
					w.cond = COND_ALWAYS;
					w.target = STEP_RESP;
					w.rm_done = 1'b1;
				end
				STEP_MISS: begin
					w.append = 1'b1;
				end
				STEP_RESP: begin
					w.respond = 1'b1;
				end
				default: begin
					w = '0;
				end
			endcase
			return w;
		end
	endfunction

endpackage
`default_nettype wire

>>> hdl/unique_key_compacting_table.sv
// Top level of the unique-key compacting table: storage, datapath and sequencer.
//
// A command word (action, key, price) is taken at a rising edge where start is
// high and busy is low. Busy then stays high until the command is finished.
// The answer word (ok, found_price, entry_count) is shown on rsp for exactly
// one cycle, marked by done; the receiver cannot hold it off, and busy is
// already low in that cycle, so the next command may be issued alongside it.
//
// Entries sit packed in insertion order in a single-port-read, single-port-
// write memory with a registered read. A microprogram walks the memory one
// entry at a time, a read step followed by a compare step. A lookup hit or a
// refused duplicate add answers at the matching entry; a miss, and so every
// add of a new key, scans all entries first. A remove that hits searches up
// to the match and then moves each later entry down one slot, a read step
// and a write step each, to close the gap. Search and shift share the memory
// port.
//
// Reset clears the entry count, the answer strobe and the sequencer; the
// memory is not cleared, since only entries below the count are ever used.
`default_nettype none
module unique_key_compacting_table #(
	parameter int CAPACITY = ukct_pkg::DEF_CAPACITY
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ukct_pkg::cmd_t cmd,
	output logic               busy,
	output logic               done,
	output ukct_pkg::rsp_t     rsp
);

	// Count needs to reach CAPACITY itself; address covers 0..CAPACITY-1.
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	ukct_pkg::ctl_t   ctl;
	ukct_pkg::stat_t  stat;
	logic             take;

	ukct_pkg::cmd_t   cmd_q;
	ukct_pkg::entry_t rd_q;
	ukct_pkg::entry_t mem [CAPACITY];
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    cnt_q;
	logic             ok_q;
	logic signed [31:0] found_q;
	logic             done_q;

	logic             accept;
	logic [CW:0]      idx_nxt;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic             append_go;
	logic             wr_en;
	ukct_pkg::entry_t wr_data;

	ukct_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.take   (take),
		.busy   (busy)
	);

	assign accept  = start && !busy;
	assign idx_nxt = {1'b0, idx_q} + 1'b1;

	// Status back to the sequencer. The scan ends once the index reaches
	// the count; the shift ends when no entry lies above the current slot.
	assign stat.at_end    = (idx_q == cnt_q);
	assign stat.match     = (rd_q.key == cmd_q.key);
	assign stat.is_remove = (cmd_q.action == ukct_pkg::ACT_REMOVE);
	assign stat.shift_end = (idx_nxt >= {1'b0, cnt_q});

	// A read during the scan looks at the current slot, during the shift at
	// the slot above it. An address one past the last entry may be read when
	// the loop is about to exit; that data is never used.
	assign rd_addr = ctl.rd_next ? idx_nxt[AW-1:0] : idx_q[AW-1:0];

	// An add lands at the end of the table only if the key was not found
	// and there is room left.
	assign append_go = ctl.append && (cmd_q.action == ukct_pkg::ACT_ADD)
		&& (cnt_q < CW'(CAPACITY));
	assign wr_en     = append_go || ctl.shift_wr;
	assign wr_addr   = ctl.shift_wr ? idx_q[AW-1:0] : cnt_q[AW-1:0];
	assign wr_data   = ctl.shift_wr ? rd_q : {cmd_q.key, cmd_q.price};

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Command latch, walk index and answer fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			idx_q   <= '0;
			ok_q    <= 1'b0;
			found_q <= '1;
		end else begin
			if ((ctl.idx_inc_taken && take) || ctl.shift_wr) begin
				idx_q <= idx_nxt[CW-1:0];
			end
			if (ctl.hit && (cmd_q.action == ukct_pkg::ACT_LOOKUP)) begin
				ok_q    <= 1'b1;
				found_q <= rd_q.price;
			end
			if (ctl.rm_done || append_go) begin
				ok_q <= 1'b1;
			end
		end
	end

	// Entry count and the one-cycle answer strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.respond;
			if (append_go) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctl.rm_done) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign done            = done_q;
	assign rsp.ok          = ok_q;
	assign rsp.found_price = found_q;
	assign rsp.entry_count = ukct_pkg::COUNT_W'(cnt_q);

endmodule
`default_nettype wire

>>> hdl/ukct_useq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none
module ukct_useq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ukct_pkg::stat_t stat,
	output ukct_pkg::ctl_t     ctl,
	output logic               take,
	output logic               busy
);

	logic [ukct_pkg::PC_W-1:0] pc_q;

	assign ctl  = ukct_pkg::ucode(pc_q);
	assign busy = (pc_q != ukct_pkg::STEP_IDLE);

	always_comb begin
		unique case (ctl.cond)
			ukct_pkg::COND_ALWAYS:    take = 1'b1;
			ukct_pkg::COND_END:       take = stat.at_end;
			ukct_pkg::COND_NOMATCH:   take = !stat.match;
			ukct_pkg::COND_NOTREMOVE: take = !stat.is_remove;
			ukct_pkg::COND_SHEND:     take = stat.shift_end;
			default:                  take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ukct_pkg::STEP_IDLE;
		end else if (pc_q == ukct_pkg::STEP_IDLE) begin
			if (start) begin
				pc_q <= ukct_pkg::STEP_SCAN;
			end
		end else if (take) begin
			pc_q <= ctl.target;
		end else if (ctl.respond) begin
			pc_q <= ukct_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule
`default_nettype wire
